### sv/ffla_pkg.sv
// shared types, codes and constants of the first-fit lane allocator
package ffla_pkg;

    // number of lane rows held in the occupancy grid
    localparam int ROW_COUNT = 64;
    localparam int ROW_AW = $clog2(ROW_COUNT);

    // defaults of the top-level parameters
    localparam int TIMELINE_LENGTH_DEF = 64;
    localparam int MAX_LANES_DEF = 64;

    // configuration register
    localparam int TL_W = 7;
    localparam logic [TL_W-1:0] TL_RESET = 7'd64;

    // action codes (code 3 is unused and leaves the state alone)
    typedef enum logic [1:0] {
        ACT_FIRST = 2'd0,
        ACT_FIXED = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_LANE = 2'd1,
        ST_TIME    = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_PUSH
    } state_t;

    // input transaction
    typedef struct packed {
        logic [1:0] action;
        logic [5:0] start_time;
        logic [5:0] end_time;
        logic [5:0] lane;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [5:0] granted_lane;
        logic [6:0] lanes_used;
        status_t    status;
    } out_item_t;

endpackage

### sv/ffla_ram.sv
// generic simple dual-port ram with registered read
module ffla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/first_fit_lane_allocator_core.sv
// first-fit lane allocator: occupancy grid in ram, read-check-write sequencer
//
//   channel   signals                          direction  transaction
//   input     in_valid  in_ready  in_item      in         one request
//   result    out_valid out_ready out_item     out        one result per request
//   config    cfg_wr_en cfg_wr_data            in         timeline length write
//
// reserve actions go from acceptance through S_READ, then S_CHECK once per lane row
// probed (one ram read per cycle, registered read), then S_PUSH; clear, error and
// unused actions go from acceptance straight to S_PUSH.
// reset clears the row valid bits at once, so the grid reads as free with no sweep.
// a held result in the output register does not block the next request; a result
// finished while the output register is still full waits in the sequencer.
module first_fit_lane_allocator_core #(
    parameter int TIMELINE_LENGTH = ffla_pkg::TIMELINE_LENGTH_DEF,
    parameter int MAX_LANES = ffla_pkg::MAX_LANES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffla_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ffla_pkg::out_item_t out_item,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data
);

    import ffla_pkg::*;

    localparam int LANE_LIMIT = (MAX_LANES < ROW_COUNT) ? MAX_LANES : ROW_COUNT;
    localparam logic [6:0] LANE_LIMIT_W = 7'(LANE_LIMIT);
    localparam logic [TL_W-1:0] TL_MAX = TL_W'(TIMELINE_LENGTH);

    state_t                    state_reg, state_next;
    logic [ROW_COUNT-1:0]      row_valid_reg, row_valid_next;
    logic [6:0]                liu_reg, liu_next;
    logic [TL_W-1:0]           tl_reg;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_item_reg, out_item_next;
    out_item_t                 res_reg, res_next;
    logic [ROW_AW-1:0]         cur_reg, cur_next;
    logic [1:0]                act_reg, act_next;
    logic [TIMELINE_LENGTH-1:0] mask_reg, mask_next;

    logic [TL_W-1:0]           eff_len;
    logic [TIMELINE_LENGTH-1:0] in_mask;
    logic [TIMELINE_LENGTH-1:0] row_cur;
    logic                      row_free;
    logic [6:0]                cur_plus;
    logic                      empty_iv;
    logic                      time_err;
    logic                      lane_err;

    logic                      wr_en;
    logic [TIMELINE_LENGTH-1:0] wr_data;
    logic [ROW_AW-1:0]         rd_addr;
    logic [TIMELINE_LENGTH-1:0] rd_data;

    // occupancy grid, one row per lane
    ffla_ram #(
        .WIDTH(TIMELINE_LENGTH),
        .DEPTH(ROW_COUNT)
    ) u_grid (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(cur_reg),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // interval mask of the incoming request, empty when start is after end
    always_comb
    begin
        for (int i = 0; i < TIMELINE_LENGTH; i++)
        begin
            in_mask[i] = (7'(i) >= {1'b0, in_item.start_time}) &&
                         (7'(i) <= {1'b0, in_item.end_time});
        end
    end

    // request checks
    assign eff_len  = (tl_reg < TL_MAX) ? tl_reg : TL_MAX;
    assign empty_iv = in_item.start_time > in_item.end_time;
    assign time_err = !empty_iv && ({1'b0, in_item.end_time} >= eff_len);
    assign lane_err = {1'b0, in_item.lane} >= LANE_LIMIT_W;

    // probed row, a row never written since the last clear reads as free
    assign row_cur  = row_valid_reg[cur_reg] ? rd_data : '0;
    assign row_free = (row_cur & mask_reg) == '0;
    assign cur_plus = {1'b0, cur_reg} + 7'd1;
    assign wr_data  = row_cur | mask_reg;

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        liu_next       = liu_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        res_next       = res_reg;
        cur_next       = cur_reg;
        act_next       = act_reg;
        mask_next      = mask_reg;
        wr_en          = 1'b0;
        rd_addr        = cur_reg;
        in_ready       = (state_reg == S_IDLE);

        // output register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = in_item.action;
                    cur_next  = in_item.lane;
                    mask_next = in_mask;
                    res_next  = '{granted_lane: '0, lanes_used: liu_reg, status: ST_OK};
                    state_next = S_PUSH;
                    if (in_item.action == ACT_CLEAR)
                    begin
                        row_valid_next = '0;
                        liu_next = '0;
                        res_next.lanes_used = '0;
                    end
                    else if (in_item.action == ACT_FIRST || in_item.action == ACT_FIXED)
                    begin
                        priority if (time_err)
                        begin
                            res_next.status = ST_TIME;
                        end
                        else if (lane_err)
                        begin
                            res_next.status = ST_NO_LANE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // read the next lane ahead in case this one is taken
                rd_addr = cur_plus[ROW_AW-1:0];
                if (act_reg == ACT_FIXED || row_free)
                begin
                    wr_en = 1'b1;
                    row_valid_next[cur_reg] = 1'b1;
                    if (cur_plus > liu_reg)
                    begin
                        liu_next = cur_plus;
                    end
                    res_next = '{granted_lane: cur_reg,
                                 lanes_used: (cur_plus > liu_reg) ? cur_plus : liu_reg,
                                 status: ST_OK};
                    state_next = S_PUSH;
                end
                else if (cur_plus >= LANE_LIMIT_W)
                begin
                    res_next = '{granted_lane: '0, lanes_used: liu_reg, status: ST_NO_LANE};
                    state_next = S_PUSH;
                end
                else
                begin
                    cur_next = cur_plus[ROW_AW-1:0];
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            liu_reg       <= '0;
            out_valid_reg <= 1'b0;
            tl_reg        <= TL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            liu_reg       <= liu_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tl_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        res_reg      <= res_next;
        cur_reg      <= cur_next;
        act_reg      <= act_next;
        mask_reg     <= mask_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // lane count never passes the lane limit
    a_liu_limit: assert property (@(posedge clk) disable iff (!rst_n)
        liu_reg <= LANE_LIMIT_W)
        else $error("lanes in use beyond lane limit");

    // the search never probes a lane at or past the limit
    a_probe_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> {1'b0, cur_reg} < LANE_LIMIT_W)
        else $error("probe beyond lane limit");

    // a good result with lanes in use grants a lane below the count
    a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status == ST_OK && out_item_reg.lanes_used != '0)
        |-> ({1'b0, out_item_reg.granted_lane} < out_item_reg.lanes_used))
        else $error("granted lane not covered by lanes in use");

endmodule

### tb/sv/tb_first_fit_lane_allocator_core.sv
// self-checking testbench for the first-fit lane allocator core
`timescale 1ns / 100ps

module tb_first_fit_lane_allocator_core;
    import ffla_pkg::*;

    // action code 3 is unused by the block and must leave the grid alone
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int LANE_CAP = (MAX_LANES_DEF < ROW_COUNT) ? MAX_LANES_DEF : ROW_COUNT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 165;
    localparam int PRINT_CAP = 100;

    typedef struct {
        bit         is_cfg;
        bit         typed;
        logic [6:0] cfg_val;
        in_item_t   req;
        out_item_t  res;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;

    // occupancy grid mirror and register copy
    logic [63:0] lane_grid [ROW_COUNT];
    logic [6:0]  lanes_taken;
    logic [6:0]  timeline_len;

    out_item_t grant_q [$];
    dir_row_t  dir_rows [$];
    int        err_count = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        send_gaps = 1'b1;
    bit        drain_stalls = 1'b1;

    first_fit_lane_allocator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // expected grant for one request, updating the mirrored grid
    function automatic out_item_t predict_grant(in_item_t req);
        out_item_t   res;
        logic [63:0] span;
        int          eff_len;
        int          probe;
        int          b;
        bit          empty;
        res = '0;
        eff_len = (int'(timeline_len) < TIMELINE_LENGTH_DEF) ?
                  int'(timeline_len) : TIMELINE_LENGTH_DEF;
        empty = req.start_time > req.end_time;
        span = '0;
        if (!empty)
        begin
            for (b = 0; b < 64; b++)
            begin
                if (b >= int'(req.start_time) && b <= int'(req.end_time))
                    span[b] = 1'b1;
            end
        end
        case (req.action)
            ACT_CLEAR:
            begin
                foreach (lane_grid[i])
                    lane_grid[i] = '0;
                lanes_taken = '0;
            end
            ACT_FIRST, ACT_FIXED:
            begin
                if (!empty && int'(req.end_time) >= eff_len)
                    res.status = ST_TIME;
                else if (int'(req.lane) >= LANE_CAP)
                    res.status = ST_NO_LANE;
                else
                begin
                    probe = int'(req.lane);
                    // first fit: walk up until the interval is free on a lane
                    if (req.action == ACT_FIRST)
                    begin
                        while (probe < LANE_CAP && (lane_grid[probe] & span) != '0)
                            probe++;
                    end
                    if (probe >= LANE_CAP)
                        res.status = ST_NO_LANE;
                    else
                    begin
                        lane_grid[probe] = lane_grid[probe] | span;
                        if (probe + 1 > int'(lanes_taken))
                            lanes_taken = 7'(probe + 1);
                        res.granted_lane = 6'(probe);
                    end
                end
            end
            default: ;
        endcase
        res.lanes_used = lanes_taken;
        return res;
    endfunction

    // directed table rows
    function automatic void add_req(logic [1:0] act, int st, int en, int ln, bit typed = 1'b0,
                                    int g = 0, int used = 0, status_t s = ST_OK);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.typed = typed;
        r.cfg_val = '0;
        r.req.action = act;
        r.req.start_time = 6'(st);
        r.req.end_time = 6'(en);
        r.req.lane = 6'(ln);
        r.res.granted_lane = 6'(g);
        r.res.lanes_used = 7'(used);
        r.res.status = s;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_cfg(int val);
        dir_row_t r;
        r.is_cfg = 1'b1;
        r.typed = 1'b0;
        r.cfg_val = 7'(val);
        r.req = '0;
        r.res = '0;
        dir_rows = {dir_rows, r};
    endfunction

    // random request shaped around the current timeline length
    function automatic in_item_t random_request();
        in_item_t r;
        int       pick;
        int       eff_len;
        int       last;
        eff_len = (int'(timeline_len) < TIMELINE_LENGTH_DEF) ?
                  int'(timeline_len) : TIMELINE_LENGTH_DEF;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.action = ACT_CLEAR;
        else if (pick < 6)
            r.action = ACT_UNUSED;
        else if (pick < 30)
            r.action = ACT_FIXED;
        else
            r.action = ACT_FIRST;
        if ($urandom_range(0, 3) == 0)
            r.lane = 6'($urandom_range(0, 63));
        else
            r.lane = 6'($urandom_range(0, 7));
        // mostly short in-range intervals, some raw noise for errors and empties
        if ($urandom_range(0, 9) == 0 || eff_len == 0)
        begin
            r.start_time = 6'($urandom_range(0, 63));
            r.end_time = 6'($urandom_range(0, 63));
        end
        else
        begin
            r.start_time = 6'($urandom_range(0, eff_len - 1));
            last = int'(r.start_time) + $urandom_range(0, 7);
            r.end_time = 6'((last < eff_len) ? last : eff_len - 1);
        end
        return r;
    endfunction

    // one request transaction; returns at the falling edge after acceptance
    task automatic push_request(in_item_t req, bit typed, out_item_t typed_res);
        out_item_t predicted;
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_grant(req);
        if (typed)
            predicted = typed_res;
        grant_q = {grant_q, predicted};
        @(negedge clk);
    endtask

    // wait until every pending result has come back and the block is idle
    task automatic settle_idle(int tail);
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_length(logic [6:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        timeline_len = val;
    endtask

    task automatic report_mismatch(string what);
        if (err_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_q.size() == 0)
                report_mismatch($sformatf("result with no request pending (lane %0d)",
                                          out_item.granted_lane));
            else
            begin
                if (out_item.granted_lane !== grant_q[0].granted_lane)
                    report_mismatch($sformatf("granted_lane got %0d expected %0d",
                                              out_item.granted_lane, grant_q[0].granted_lane));
                if (out_item.lanes_used !== grant_q[0].lanes_used)
                    report_mismatch($sformatf("lanes_used got %0d expected %0d",
                                              out_item.lanes_used, grant_q[0].lanes_used));
                if (out_item.status !== grant_q[0].status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              out_item.status, grant_q[0].status));
                void'(grant_q.pop_front());
            end
        end
    end

    // receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (drain_stalls && stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (drain_stalls && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("first_fit_lane_allocator_core verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int k;
        int p;
        int n;
        int phase_len [PHASE_COUNT];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        foreach (lane_grid[i])
            lane_grid[i] = '0;
        lanes_taken = '0;
        timeline_len = TL_RESET;

        // directed: reset state, full rows, top lane, exhausted search, errors
        add_req(ACT_UNUSED, 0, 0, 5, 1'b1, 0, 0, ST_OK);
        add_req(ACT_FIRST, 0, 63, 0, 1'b1, 0, 1, ST_OK);
        add_req(ACT_FIRST, 0, 63, 0, 1'b1, 1, 2, ST_OK);
        add_req(ACT_FIXED, 10, 5, 63, 1'b1, 63, 64, ST_OK);
        add_req(ACT_FIRST, 0, 0, 63);
        add_req(ACT_FIRST, 0, 0, 63, 1'b1, 0, 64, ST_NO_LANE);
        add_req(ACT_FIXED, 63, 63, 0, 1'b1, 0, 64, ST_OK);
        add_req(ACT_FIRST, 5, 4, 40, 1'b1, 40, 64, ST_OK);
        add_req(ACT_CLEAR, 0, 0, 0, 1'b1, 0, 0, ST_OK);
        add_req(ACT_FIRST, 63, 0, 63, 1'b1, 63, 64, ST_OK);
        add_req(ACT_CLEAR, 63, 63, 63, 1'b1, 0, 0, ST_OK);
        add_req(ACT_FIRST, 0, 63, 62, 1'b1, 62, 63, ST_OK);
        add_req(ACT_FIRST, 0, 63, 62, 1'b1, 63, 64, ST_OK);
        add_req(ACT_FIRST, 0, 63, 62, 1'b1, 0, 64, ST_NO_LANE);
        add_req(ACT_FIXED, 20, 30, 62, 1'b1, 62, 64, ST_OK);
        add_req(ACT_FIRST, 3, 3, 0);
        add_req(ACT_UNUSED, 63, 63, 63, 1'b1, 0, 64, ST_OK);
        add_req(ACT_CLEAR, 21, 42, 21, 1'b1, 0, 0, ST_OK);
        add_req(ACT_FIRST, 42, 21, 21);
        add_req(ACT_FIRST, 21, 42, 42);
        add_req(ACT_FIRST, 30, 35, 42);
        add_req(ACT_FIXED, 0, 63, 5);
        add_cfg(16);
        add_req(ACT_CLEAR, 0, 0, 0, 1'b1, 0, 0, ST_OK);
        add_req(ACT_FIRST, 10, 16, 3, 1'b1, 0, 0, ST_TIME);
        add_req(ACT_FIXED, 5, 3, 7, 1'b1, 7, 8, ST_OK);
        add_req(ACT_FIRST, 15, 15, 0, 1'b1, 0, 8, ST_OK);
        add_req(ACT_FIXED, 16, 16, 0, 1'b1, 0, 8, ST_TIME);

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table walk
        for (k = 0; k < dir_rows.size(); k++)
        begin
            if (dir_rows[k].is_cfg)
            begin
                settle_idle(4);
                write_length(dir_rows[k].cfg_val);
            end
            else
                push_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
        end

        // random phases over several timeline lengths, extremes included
        phase_len = '{1, 64, 0, 127, 2, 33, 8, 64};
        phase_len[4] = $urandom_range(2, 63);
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            settle_idle(4);
            send_gaps = (p != 3 && p != PHASE_COUNT - 1);
            drain_stalls = send_gaps;
            write_length(7'(phase_len[p]));
            for (n = 0; n < PHASE_ITEMS; n++)
                push_request(random_request(), 1'b0, '0);
        end

        settle_idle(8);
        if (err_count == 0)
            $display("first_fit_lane_allocator_core verification clean");
        else
            $display("first_fit_lane_allocator_core verification failed");
        $finish;
    end

endmodule
